/* hw/rtl/length_prefixed_frame_receiver_assert.svh */
// Assertion macros for the frame receiver; clk and rst_n come from the using scope.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define LFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF  = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [7:0]  RX_ID_RST    = 8'h00;
  localparam logic [15:0] BUF_SIZE_RST = 16'd256;
  localparam logic [31:0] MAX_TIME_RST = 32'd0;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_ID    = 2'd0,
    CFG_TWO_BYTE = 2'd1,
    CFG_BUF_SIZE = 2'd2,
    CFG_MAX_TIME = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  rx_id;
    logic        two_byte_length;
    logic [15:0] buffer_size;
    logic [31:0] max_time;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_addr;
    logic [7:0]  store_byte;
    logic        frame_ready;
    logic [15:0] frame_length;
    logic        timed_out;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/lfr_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfr_cfg
  import lfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rx_id           <= RX_ID_RST;
      cfg_r.two_byte_length <= 1'b0;
      cfg_r.buffer_size     <= BUF_SIZE_RST;
      cfg_r.max_time        <= MAX_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RX_ID:    cfg_r.rx_id           <= cfg_data[7:0];
        CFG_TWO_BYTE: cfg_r.two_byte_length <= cfg_data[0];
        CFG_BUF_SIZE: cfg_r.buffer_size     <= cfg_data[15:0];
        CFG_MAX_TIME: cfg_r.max_time        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lfr_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfr_in_stage
  import lfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_rx_byte,
  output logic            item_valid,
  output item_t           item,
  input  wire logic       item_ready
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        item_r.cmd     <= cmd_t'(in_cmd);
        item_r.rx_byte <= in_rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lfr_step.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_frame_receiver_assert.svh"

module lfr_step
  import lfr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic item_valid,
  input  wire item_t item,
  output logic      item_ready,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_P1     = 3'd1,
    PH_P2     = 3'd2,
    PH_P3     = 3'd3,
    PH_P4     = 3'd4
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [LENGTH_BITS-1:0] exp_r, exp_nxt;
  logic                   ready_r, ready_nxt;
  logic                   run_r, run_nxt;
  logic [TIMER_BITS-1:0]  elap_r, elap_nxt;
  logic                   res_valid_r;
  res_t                   res_r, res_nxt;

  logic                   take;
  logic [7:0]             b;
  logic                   sv;
  logic [15:0]            addr;
  logic                   tout;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] exp_sum;
  logic [TIMER_BITS-1:0]  elap_inc;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  assign b        = item.rx_byte;
  assign cnt_inc  = count_r + LENGTH_BITS'(1);
  assign exp_sum  = exp_r + LENGTH_BITS'(b);
  assign elap_inc = (elap_r == '1) ? elap_r : elap_r + TIMER_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    exp_nxt   = exp_r;
    ready_nxt = ready_r;
    run_nxt   = run_r;
    elap_nxt  = elap_r;
    sv        = 1'b0;
    addr      = '0;
    tout      = 1'b0;
    unique case (item.cmd)
      CMD_BYTE: begin
        if (phase_r == PH_HEADER) begin
          if (count_r == '0 && b == cfg.rx_id) begin
            sv        = 1'b1;
            phase_nxt = PH_P1;
            run_nxt   = 1'b1;
            elap_nxt  = '0;
          end
        end else if (!cfg.two_byte_length) begin
          unique case (phase_r)
            PH_P1: begin
              if (b != 8'h00 && b < cfg.buffer_size[7:0]) begin
                sv        = 1'b1;
                addr      = 16'd1;
                exp_nxt   = LENGTH_BITS'(b);
                phase_nxt = PH_P2;
              end else begin
                phase_nxt = PH_HEADER;
              end
              run_nxt  = 1'b1;
              elap_nxt = '0;
            end
            PH_P2: begin
              sv        = 1'b1;
              addr      = 16'(17'(count_r) + 17'd2);
              count_nxt = cnt_inc;
              if (cnt_inc >= exp_r) begin
                phase_nxt = PH_P3;
                ready_nxt = 1'b1;
              end
              run_nxt  = 1'b1;
              elap_nxt = '0;
            end
            default: run_nxt = 1'b0;
          endcase
        end else begin
          unique case (phase_r)
            PH_P1: begin
              sv        = 1'b1;
              addr      = 16'd1;
              exp_nxt   = LENGTH_BITS'({b, 8'h00});
              phase_nxt = PH_P2;
              run_nxt   = 1'b1;
              elap_nxt  = '0;
            end
            PH_P2: begin
              sv      = 1'b1;
              addr    = 16'd2;
              exp_nxt = exp_sum;
              if (exp_sum != '0 && 16'(exp_sum) < cfg.buffer_size) begin
                phase_nxt = PH_P3;
              end else begin
                phase_nxt = PH_HEADER;
              end
              run_nxt  = 1'b1;
              elap_nxt = '0;
            end
            PH_P3: begin
              sv        = 1'b1;
              addr      = 16'(17'(count_r) + 17'd3);
              count_nxt = cnt_inc;
              if (cnt_inc >= exp_r) begin
                phase_nxt = PH_P4;
                ready_nxt = 1'b1;
              end
              run_nxt  = 1'b1;
              elap_nxt = '0;
            end
            default: run_nxt = 1'b0;
          endcase
        end
      end
      CMD_TICK: begin
        if (run_r) begin
          elap_nxt = elap_inc;
          if (cfg.max_time != 32'd0 && 32'(elap_inc) >= cfg.max_time) begin
            phase_nxt = PH_HEADER;
            count_nxt = '0;
            exp_nxt   = '0;
            ready_nxt = 1'b0;
            run_nxt   = 1'b0;
            elap_nxt  = '0;
            tout      = 1'b1;
          end
        end
      end
      CMD_RESTART: begin
        phase_nxt = PH_HEADER;
        count_nxt = '0;
        exp_nxt   = '0;
        ready_nxt = 1'b0;
        run_nxt   = 1'b0;
        elap_nxt  = '0;
      end
      default: ;
    endcase

    res_nxt.store_valid  = sv;
    res_nxt.store_addr   = addr;
    res_nxt.store_byte   = sv ? b : 8'h00;
    res_nxt.frame_ready  = ready_nxt;
    res_nxt.frame_length = 16'(exp_nxt);
    res_nxt.timed_out    = tout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      count_r     <= '0;
      exp_r       <= '0;
      ready_r     <= 1'b0;
      run_r       <= 1'b0;
      elap_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (item_ready) begin
        res_valid_r <= item_valid;
      end
      if (take) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        exp_r   <= exp_nxt;
        ready_r <= ready_nxt;
        run_r   <= run_nxt;
        elap_r  <= elap_nxt;
        res_r   <= res_nxt;
      end
    end
  end

  `LFR_ASSERT_IMP(a_tout_clears, res_valid_r && res_r.timed_out, !res_r.store_valid && !res_r.frame_ready && (res_r.frame_length == '0), "timeout result without a cleared receiver")
  `LFR_ASSERT_IMP(a_idle_store_zero, res_valid_r && !res_r.store_valid, (res_r.store_addr == '0) && (res_r.store_byte == '0), "unstored byte shows address or data")
  `LFR_ASSERT_IMP(a_ready_hold, $fell(ready_r), !$past(rst_n) || ($past(take) && ($past(item.cmd) == CMD_TICK || $past(item.cmd) == CMD_RESTART)), "frame ready dropped without restart or timeout")
  `LFR_ASSERT_NXT(a_timer_start, !run_r && !(take && item.cmd == CMD_BYTE), !run_r, "timer started without a received byte")

endmodule

`default_nettype wire

/* hw/rtl/length_prefixed_frame_receiver.sv */
// A transaction accepted at the input is held in the input register, then passes through
// the receive state update into the result register, which drives the outputs.
// Throughput: one transaction per cycle (byte, tick or restart), back to back while out_ready
// is high, bound by the single receive state update between input and result registers.
// Reset: synchronous, active low; clears receive state, timer and the valid flags of both
// pipeline registers and returns the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver
  import lfr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_store_valid,
  output logic [15:0]                out_store_addr,
  output logic [7:0]                 out_store_byte,
  output logic                       out_frame_ready,
  output logic [15:0]                out_frame_length,
  output logic                       out_timed_out
);

  cfg_t  cfg;
  logic  item_valid;
  logic  item_ready;
  item_t item;
  res_t  res;

  lfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  lfr_step #(
    .LENGTH_BITS (LENGTH_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (out_valid),
    .res        (res),
    .res_ready  (out_ready)
  );

  assign out_store_valid  = res.store_valid;
  assign out_store_addr   = res.store_addr;
  assign out_store_byte   = res.store_byte;
  assign out_frame_ready  = res.frame_ready;
  assign out_frame_length = res.frame_length;
  assign out_timed_out    = res.timed_out;

endmodule

`default_nettype wire
